/* rtl/ps2mt_pkg.sv */
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by ps2mt_divider, ps2mt_clamp and ps2_mouse_packet_tracker; no dependencies.
package ps2mt_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET_X,
		ST_SET_Y,
		ST_DIV_X,
		ST_MOV_X,
		ST_DIV_Y,
		ST_MOV_Y,
		ST_EMIT
	} state_t;

	// Event codes on event_type
	typedef enum logic [1:0] {
		EV_LEFT_PRESS   = 2'd0,
		EV_LEFT_RELEASE = 2'd1,
		EV_SCROLL       = 2'd2,
		EV_MOVE         = 2'd3
	} event_t;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_ENABLED  = 3'd0;
	localparam logic [2:0] REG_LIMIT_X  = 3'd1;
	localparam logic [2:0] REG_LIMIT_Y  = 3'd2;
	localparam logic [2:0] REG_DIV_X    = 3'd3;
	localparam logic [2:0] REG_DIV_Y    = 3'd4;
	localparam logic [2:0] REG_WHEEL    = 3'd5;

	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int LIMIT_W  = 12;
	localparam int CURSOR_W = 12;
	localparam int DELTA_W  = 9;
	localparam int WHEEL_W  = 4;
	localparam int DIV_W    = 4;
	localparam int SETPOS_W = 13;

	// Reset values
	localparam logic [LIMIT_W-1:0] RESET_LIMIT_X = 12'd639;
	localparam logic [LIMIT_W-1:0] RESET_LIMIT_Y = 12'd479;
	localparam logic [LIMIT_W-1:0] RESET_POS_X   = 12'd320;
	localparam logic [LIMIT_W-1:0] RESET_POS_Y   = 12'd240;

	// Divisor saturation bounds
	localparam logic [DIV_W-1:0] DIV_MIN = 4'd1;
	localparam logic [DIV_W-1:0] DIV_MAX = 4'd8;

	// Packet flag byte bits
	localparam int SYNC_BIT  = 3;
	localparam int OVF_X_BIT = 6;
	localparam int OVF_Y_BIT = 7;
	localparam logic [7:0] WHEEL_MASK = 8'h0F;

	// One quotient bit per divider step over an 8-bit magnitude
	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Divider control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// Magnitude of a two's complement byte (0x80 gives 128)
	function automatic logic [7:0] mag8(input logic [7:0] b);
		logic [7:0] r;
		r = b[7] ? (~b + 8'd1) : b;
		return r;
	endfunction

	// Saturate a written divisor into 1..8
	function automatic logic [DIV_W-1:0] sat_div(input logic [DIV_W-1:0] v);
		logic [DIV_W-1:0] r;
		if (v < DIV_MIN) r = DIV_MIN;
		else if (v > DIV_MAX) r = DIV_MAX;
		else r = v;
		return r;
	endfunction

endpackage

/* rtl/ps2mt_divider.sv */
// Bit-serial restoring divider: 8-bit magnitude by a 1..8 divisor, one quotient bit a cycle while step is asserted.
// Depends on ps2mt_pkg.
module ps2mt_divider import ps2mt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctrl_t        ctrl,
	input  logic [7:0]       dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [7:0]       quotient,
	output logic             done
);

	logic [DIV_W:0]     rem_q;
	logic [7:0]         dvd_q;
	logic [7:0]         quo_q;
	logic [DIV_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DIV_W:0] trial;
	logic           fits;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q[DIV_W-1:0], dvd_q[7]};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (ctrl.load) begin
			cnt_q <= '0;
		end else if (ctrl.step && !done) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rem_q <= '0;
			dvd_q <= dividend;
			quo_q <= '0;
			dsr_q <= divisor;
		end else if (ctrl.step && !done) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			dvd_q <= {dvd_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], fits};
		end
	end

	assign done     = cnt_q == DIV_CNT_W'(DIV_STEPS);
	assign quotient = quo_q;

endmodule

/* rtl/ps2mt_clamp.sv */
// Clamps a signed position candidate into 0..min(limit, largest position value).
// Depends on ps2mt_pkg.
module ps2mt_clamp import ps2mt_pkg::*; #(
	parameter int POSITION_BITS = 12,
	parameter int SUM_W         = 15
) (
	input  logic signed [SUM_W-1:0]   value,
	input  logic [LIMIT_W-1:0]        limit,
	output logic [POSITION_BITS-1:0]  result
);

	localparam logic [SUM_W-1:0] POS_MAX = (SUM_W'(1) << POSITION_BITS) - SUM_W'(1);

	logic [SUM_W-1:0] lim_ext;
	logic [SUM_W-1:0] hi;

	// Upper bound is the smaller of the limit and the position range
	always_comb begin
		lim_ext = SUM_W'(limit);
		hi      = (lim_ext > POS_MAX) ? POS_MAX : lim_ext;
		if (value[SUM_W-1]) begin
			result = '0;
		end else if (SUM_W'(value) > hi) begin
			result = POSITION_BITS'(hi);
		end else begin
			result = POSITION_BITS'(value);
		end
	end

endmodule

/* rtl/ps2_mouse_packet_tracker.sv */
// PS/2 mouse packet tracker: a byte or set-position word enters on the input channel; a
// non-mover byte leaves the sequencer idle, a set-position request steps through SET_X and SET_Y,
// and a completed packet goes through the shared bit-serial divider, for X and then for Y.
// The input stalls while a word is in work; a finished event waits in the output register, and
// the sequencer holds in its last state only if a second event is ready before that one is taken.
// Configuration sits on an APB-style port, registers at byte address 4*index.
// Depends on ps2mt_pkg, ps2mt_divider and ps2mt_clamp.
module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
	parameter int POSITION_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [7:0]                 rx_byte,
	input  logic signed [SETPOS_W-1:0] new_x,
	input  logic signed [SETPOS_W-1:0] new_y,
	// output channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 event_type,
	output logic [CURSOR_W-1:0]        cursor_x,
	output logic [CURSOR_W-1:0]        cursor_y,
	output logic signed [DELTA_W-1:0]  delta_x,
	output logic signed [DELTA_W-1:0]  delta_y,
	output logic signed [WHEEL_W-1:0]  wheel_step,
	output logic [2:0]                 button_bits
);

	localparam int SUM_W = ((POSITION_BITS > SETPOS_W) ? POSITION_BITS : SETPOS_W) + 2;

	// Configuration registers
	logic                 enabled_q;
	logic [LIMIT_W-1:0]   limit_x_q, limit_y_q;
	logic [DIV_W-1:0]     div_x_q, div_y_q;
	logic                 wheel_pk_q;

	// Tracker state
	state_t               state_q, state_d;
	logic [1:0]           byte_idx_q;
	logic [7:0]           pkt_q [4];
	logic [POSITION_BITS-1:0] pos_x_q, pos_y_q;
	logic [2:0]           held_q;
	logic                 wheel_q;
	logic signed [SETPOS_W-1:0] set_x_q, set_y_q;
	logic signed [DELTA_W-1:0]  dx_q, dy_q;

	// Output register
	logic                 out_valid_q;
	event_t               ev_q;
	logic [CURSOR_W-1:0]  cur_x_q, cur_y_q;
	logic signed [DELTA_W-1:0] odx_q, ody_q;
	logic signed [WHEEL_W-1:0] owh_q;
	logic [2:0]           obtn_q;

	// Datapath nets
	logic                 wr_cfg;
	logic                 in_acc, out_acc;
	logic                 is_byte, sync_bit, pkt_last, pkt_ovf, pkt_go;
	div_ctrl_t            div_ctrl;
	logic [7:0]           div_dvd;
	logic [DIV_W-1:0]     div_dsr;
	logic [7:0]           div_quo;
	logic                 div_done;
	logic                 side_x;
	logic                 neg_d;
	logic [DELTA_W-1:0]   q_ext;
	logic signed [DELTA_W-1:0] delta_w;
	logic signed [SUM_W-1:0]   clamp_in;
	logic [LIMIT_W-1:0]   clamp_lim;
	logic [POSITION_BITS-1:0]  clamp_out;
	logic [2:0]           pressed, released;
	logic signed [WHEEL_W-1:0] wheel_w;
	logic                 has_ev, slot_free, emit_done, out_load;
	event_t               ev_w;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			limit_x_q  <= RESET_LIMIT_X;
			limit_y_q  <= RESET_LIMIT_Y;
			div_x_q    <= DIV_MIN;
			div_y_q    <= DIV_MIN;
			wheel_pk_q <= 1'b0;
		end else if (wr_cfg) begin
			case (paddr[4:2])
				REG_ENABLED: enabled_q  <= pwdata[0];
				REG_LIMIT_X: limit_x_q  <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_Y: limit_y_q  <= pwdata[LIMIT_W-1:0];
				REG_DIV_X:   div_x_q    <= sat_div(pwdata[DIV_W-1:0]);
				REG_DIV_Y:   div_y_q    <= sat_div(pwdata[DIV_W-1:0]);
				REG_WHEEL:   wheel_pk_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[4:2])
			REG_ENABLED: prdata = DATA_W'(enabled_q);
			REG_LIMIT_X: prdata = DATA_W'(limit_x_q);
			REG_LIMIT_Y: prdata = DATA_W'(limit_y_q);
			REG_DIV_X:   prdata = DATA_W'(div_x_q);
			REG_DIV_Y:   prdata = DATA_W'(div_y_q);
			REG_WHEEL:   prdata = DATA_W'(wheel_pk_q);
			default:     prdata = '0;
		endcase
	end

	// ---------------- byte framing ----------------
	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign is_byte  = in_acc && !kind && enabled_q;
	assign sync_bit = rx_byte[SYNC_BIT];
	// last byte of a packet, by the size in force now
	assign pkt_last = (byte_idx_q != 2'd0) && !sync_bit &&
		((byte_idx_q == 2'd3) || (byte_idx_q == 2'd2 && !wheel_pk_q));
	assign pkt_ovf  = pkt_q[0][OVF_X_BIT] || pkt_q[0][OVF_Y_BIT];
	assign pkt_go   = is_byte && pkt_last && !pkt_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
		end else if (in_acc && !kind) begin
			if (!enabled_q) begin
				byte_idx_q <= '0;
			end else if (byte_idx_q == 2'd0) begin
				if (sync_bit) byte_idx_q <= 2'd1;
			end else if (sync_bit) begin
				byte_idx_q <= 2'd1;
			end else if (pkt_last) begin
				byte_idx_q <= '0;
			end else begin
				byte_idx_q <= byte_idx_q + 2'd1;
			end
		end
	end

	// Packet bytes; a resync byte always lands in slot 0
	always_ff @(posedge clk) begin
		if (is_byte) begin
			if (sync_bit) begin
				pkt_q[0] <= rx_byte;
			end else if (byte_idx_q != 2'd0) begin
				pkt_q[byte_idx_q] <= rx_byte;
			end
		end
	end

	// Packet size and requested position captured at entry
	always_ff @(posedge clk) begin
		if (pkt_go) wheel_q <= wheel_pk_q;
		if (in_acc && kind) begin
			set_x_q <= new_x;
			set_y_q <= new_y;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind) state_d = ST_SET_X;
				else if (pkt_go)    state_d = ST_DIV_X;
			end
			ST_SET_X: state_d = ST_SET_Y;
			ST_SET_Y: state_d = ST_IDLE;
			ST_DIV_X: if (div_done) state_d = ST_MOV_X;
			ST_MOV_X: state_d = ST_DIV_Y;
			ST_DIV_Y: if (div_done) state_d = ST_MOV_Y;
			ST_MOV_Y: state_d = ST_EMIT;
			ST_EMIT:  if (emit_done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		div_ctrl.load = 1'b0;
		div_ctrl.step = 1'b0;
		side_x        = 1'b1;
		case (state_q)
			ST_IDLE:  div_ctrl.load = pkt_go;
			ST_SET_X: side_x = 1'b1;
			ST_SET_Y: side_x = 1'b0;
			ST_DIV_X: div_ctrl.step = 1'b1;
			ST_MOV_X: begin
				div_ctrl.load = 1'b1;
				side_x        = 1'b1;
			end
			ST_DIV_Y: begin
				div_ctrl.step = 1'b1;
				side_x        = 1'b0;
			end
			ST_MOV_Y: side_x = 1'b0;
			ST_EMIT:  side_x = 1'b0;
			default:  ;
		endcase
	end

	// ---------------- shared divider ----------------
	// X magnitude loads at packet end, Y magnitude when X finishes
	assign div_dvd = (state_q == ST_IDLE) ? mag8(pkt_q[1]) : mag8(pkt_q[2]);
	assign div_dsr = (state_q == ST_IDLE) ? div_x_q : div_y_q;

	ps2mt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Signed delta; Y is negated so screen-down is positive
	always_comb begin
		neg_d   = side_x ? pkt_q[1][7] : !pkt_q[2][7];
		q_ext   = DELTA_W'(div_quo);
		delta_w = neg_d ? -$signed(q_ext) : $signed(q_ext);
	end

	// ---------------- shared clamp ----------------
	always_comb begin
		clamp_lim = side_x ? limit_x_q : limit_y_q;
		case (state_q)
			ST_SET_X: clamp_in = {{(SUM_W-SETPOS_W){set_x_q[SETPOS_W-1]}}, set_x_q};
			ST_SET_Y: clamp_in = {{(SUM_W-SETPOS_W){set_y_q[SETPOS_W-1]}}, set_y_q};
			ST_MOV_X: clamp_in = $signed({{(SUM_W-POSITION_BITS){1'b0}}, pos_x_q}) +
				$signed({{(SUM_W-DELTA_W){delta_w[DELTA_W-1]}}, delta_w});
			ST_MOV_Y: clamp_in = $signed({{(SUM_W-POSITION_BITS){1'b0}}, pos_y_q}) +
				$signed({{(SUM_W-DELTA_W){delta_w[DELTA_W-1]}}, delta_w});
			default:  clamp_in = '0;
		endcase
	end

	ps2mt_clamp #(
		.POSITION_BITS (POSITION_BITS),
		.SUM_W         (SUM_W)
	) u_clamp (
		.value  (clamp_in),
		.limit  (clamp_lim),
		.result (clamp_out)
	);

	// Position and delta registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= POSITION_BITS'(RESET_POS_X);
			pos_y_q <= POSITION_BITS'(RESET_POS_Y);
		end else begin
			if (state_q == ST_SET_X || state_q == ST_MOV_X) pos_x_q <= clamp_out;
			if (state_q == ST_SET_Y || state_q == ST_MOV_Y) pos_y_q <= clamp_out;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MOV_X) dx_q <= delta_w;
		if (state_q == ST_MOV_Y) dy_q <= delta_w;
	end

	// ---------------- event decision ----------------
	always_comb begin
		pressed  = ~held_q & pkt_q[0][2:0];
		released = held_q & ~pkt_q[0][2:0];
		wheel_w  = wheel_q ? $signed(pkt_q[3][WHEEL_W-1:0] & WHEEL_MASK[WHEEL_W-1:0]) : '0;
		has_ev   = (pressed != '0) || (released != '0) || (dx_q != '0) ||
			(dy_q != '0) || (wheel_w != '0);
		if (pressed[0])        ev_w = EV_LEFT_PRESS;
		else if (released[0])  ev_w = EV_LEFT_RELEASE;
		else if (wheel_w != '0) ev_w = EV_SCROLL;
		else                   ev_w = EV_MOVE;
		slot_free = !out_valid_q || !out_stall;
		emit_done = (state_q == ST_EMIT) && (!has_ev || slot_free);
		out_load  = (state_q == ST_EMIT) && has_ev && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) held_q <= '0;
		else if (emit_done) held_q <= pkt_q[0][2:0];
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_acc)  out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ev_q    <= ev_w;
			cur_x_q <= CURSOR_W'(pos_x_q);
			cur_y_q <= CURSOR_W'(pos_y_q);
			odx_q   <= dx_q;
			ody_q   <= dy_q;
			owh_q   <= wheel_w;
			obtn_q  <= pkt_q[0][2:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign event_type  = ev_q;
	assign cursor_x    = cur_x_q;
	assign cursor_y    = cur_y_q;
	assign delta_x     = odx_q;
	assign delta_y     = ody_q;
	assign wheel_step  = owh_q;
	assign button_bits = obtn_q;

	// ---------------- assertions ----------------
	// Framing only moves while the sequencer is idle
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(byte_idx_q))
		else $error("byte index changed while busy");

	// Divisors stay saturated in 1..8
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_x_q >= DIV_MIN) && (div_x_q <= DIV_MAX) &&
		(div_y_q >= DIV_MIN) && (div_y_q <= DIV_MAX))
		else $error("divisor out of range");

	// Left press and release events agree with the reported buttons
	a_left_press: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_q == EV_LEFT_PRESS) |-> obtn_q[0])
		else $error("left press without left button held");

	a_left_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ev_q == EV_LEFT_RELEASE) |-> !obtn_q[0])
		else $error("left release with left button held");

	// A reported cursor never exceeds its limit
	a_cursor_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cur_x_q <= limit_x_q) && (cur_y_q <= limit_y_q))
		else $error("cursor beyond limit");

endmodule

/* tb/ps2_mouse_packet_tracker_tb.sv */
// Self-checking testbench for ps2_mouse_packet_tracker: mouse bytes and set-position words
// are driven with random gaps and output stalls, and each event is checked against a tracker.
// Depends on ps2mt_pkg and the ps2_mouse_packet_tracker RTL.
module ps2_mouse_packet_tracker_tb import ps2mt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POS_BITS = 12;
	localparam int POS_MAX = (1 << POS_BITS) - 1;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic                       kind;
		logic [7:0]                 rx;
		logic signed [SETPOS_W-1:0] nx;
		logic signed [SETPOS_W-1:0] ny;
	} mouse_word_t;

	typedef struct {
		event_t                     ev;
		logic [CURSOR_W-1:0]        cx;
		logic [CURSOR_W-1:0]        cy;
		logic signed [DELTA_W-1:0]  dx;
		logic signed [DELTA_W-1:0]  dy;
		logic signed [WHEEL_W-1:0]  wh;
		logic [2:0]                 btn;
	} mouse_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [7:0] rx_byte = '0;
	logic signed [SETPOS_W-1:0] new_x = '0, new_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] event_type;
	logic [CURSOR_W-1:0] cursor_x, cursor_y;
	logic signed [DELTA_W-1:0] delta_x, delta_y;
	logic signed [WHEEL_W-1:0] wheel_step;
	logic [2:0] button_bits;

	mouse_word_t pending_words[$];
	mouse_event_t due_events[$];
	mouse_word_t cur_word;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0, hold_seen = 1'b0;
	int hold_left = 0;
	int words_made = 0;
	int mismatches = 0;
	logic [2:0] last_btn = '0;

	// tracker copy of the registers and packet state
	logic trk_en = 1'b0;
	logic [LIMIT_W-1:0] trk_lim_x = RESET_LIMIT_X, trk_lim_y = RESET_LIMIT_Y;
	logic [DIV_W-1:0] trk_div_x = 4'd1, trk_div_y = 4'd1;
	logic trk_wheel4 = 1'b0;
	logic [1:0] trk_idx = '0;
	logic [7:0] trk_bytes [4];
	int trk_x = int'(RESET_POS_X);
	int trk_y = int'(RESET_POS_Y);
	logic [2:0] trk_btn = '0;

	ps2_mouse_packet_tracker #(.POSITION_BITS(POS_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .rx_byte(rx_byte),
		.new_x(new_x), .new_y(new_y),
		.out_valid(out_valid), .out_stall(out_stall), .event_type(event_type),
		.cursor_x(cursor_x), .cursor_y(cursor_y), .delta_x(delta_x), .delta_y(delta_y),
		.wheel_step(wheel_step), .button_bits(button_bits)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int clamp_pos(int v, logic [LIMIT_W-1:0] lim);
		int hi;
		hi = (int'(lim) > POS_MAX) ? POS_MAX : int'(lim);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	// Advance the tracker by one accepted word; queue the event it yields, if any
	task automatic track_word(input mouse_word_t w);
		int len, dx, dy, wh;
		logic [2:0] prev, pressed, released;
		mouse_event_t rpt;
		if (w.kind) begin
			trk_x = clamp_pos(int'(w.nx), trk_lim_x);
			trk_y = clamp_pos(int'(w.ny), trk_lim_y);
			return;
		end
		if (!trk_en) begin
			trk_idx = '0;
			return;
		end
		// wait for a flags byte; a flags byte mid-packet starts over
		if (trk_idx == 0 && !w.rx[SYNC_BIT]) return;
		if (trk_idx != 0 && w.rx[SYNC_BIT]) begin
			trk_bytes[0] = w.rx;
			trk_idx = 2'd1;
			return;
		end
		trk_bytes[trk_idx] = w.rx;
		len = trk_wheel4 ? 4 : 3;
		if (trk_idx + 1 < len) begin
			trk_idx = trk_idx + 2'd1;
			return;
		end
		trk_idx = '0;
		if (trk_bytes[0][OVF_X_BIT] || trk_bytes[0][OVF_Y_BIT]) return;

		prev = trk_btn;
		trk_btn = trk_bytes[0][2:0];
		dx = int'($signed(trk_bytes[1])) / int'(trk_div_x);
		dy = -int'($signed(trk_bytes[2])) / int'(trk_div_y);
		trk_x = clamp_pos(trk_x + dx, trk_lim_x);
		trk_y = clamp_pos(trk_y + dy, trk_lim_y);
		wh = (len == 4) ? int'($signed(trk_bytes[3][3:0])) : 0;
		pressed = ~prev & trk_btn;
		released = prev & ~trk_btn;
		if (pressed == 0 && released == 0 && dx == 0 && dy == 0 && wh == 0) return;

		if (pressed[0]) rpt.ev = EV_LEFT_PRESS;
		else if (released[0]) rpt.ev = EV_LEFT_RELEASE;
		else if (wh != 0) rpt.ev = EV_SCROLL;
		else rpt.ev = EV_MOVE;
		rpt.cx = trk_x[CURSOR_W-1:0];
		rpt.cy = trk_y[CURSOR_W-1:0];
		rpt.dx = dx[DELTA_W-1:0];
		rpt.dy = dy[DELTA_W-1:0];
		rpt.wh = wh[WHEEL_W-1:0];
		rpt.btn = trk_btn;
		due_events.push_back(rpt);
	endtask

	// APB write: setup, then access; the register takes it on the access edge
	task automatic set_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		logic [DIV_W-1:0] v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = val[DIV_W-1:0];
		if (v < DIV_MIN) v = DIV_MIN;
		else if (v > DIV_MAX) v = DIV_MAX;
		case (idx)
			REG_ENABLED: trk_en = val[0];
			REG_LIMIT_X: trk_lim_x = val[LIMIT_W-1:0];
			REG_LIMIT_Y: trk_lim_y = val[LIMIT_W-1:0];
			REG_DIV_X:   trk_div_x = v;
			REG_DIV_Y:   trk_div_y = v;
			REG_WHEEL:   trk_wheel4 = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(input int en, lx, ly, dvx, dvy, w4);
		set_reg(REG_ENABLED, DATA_W'(en));
		set_reg(REG_LIMIT_X, DATA_W'(lx));
		set_reg(REG_LIMIT_Y, DATA_W'(ly));
		set_reg(REG_DIV_X, DATA_W'(dvx));
		set_reg(REG_DIV_Y, DATA_W'(dvy));
		set_reg(REG_WHEEL, DATA_W'(w4));
	endtask

	// Block idle: all words taken, all events seen, plus the tail of a silent packet
	task automatic settle();
		@(negedge clk);
		while (pending_words.size() != 0 || in_valid) @(negedge clk);
		while (due_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [SETPOS_W-1:0] rand_pos();
		return SETPOS_W'(int'($urandom_range(6143)) - 2048);
	endfunction

	task automatic queue_word(input logic k, input logic [7:0] b,
			input logic signed [SETPOS_W-1:0] x, y);
		mouse_word_t w;
		w.kind = k;
		w.rx = b;
		w.nx = x;
		w.ny = y;
		pending_words.push_back(w);
		words_made++;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		queue_word(1'b0, b, rand_pos(), rand_pos());
	endtask

	task automatic queue_setpos(input logic signed [SETPOS_W-1:0] x, y);
		queue_word(1'b1, 8'($urandom), x, y);
	endtask

	task automatic queue_packet(input logic [7:0] f, bx, by, bw);
		queue_byte(f);
		queue_byte(bx);
		queue_byte(by);
		if (trk_wheel4) queue_byte(bw);
	endtask

	// Delta byte: mostly sync bit clear so the packet completes
	function automatic logic [7:0] rand_delta();
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1: b = 8'h00;
			2: b = 8'h80;
			default: b = 8'($urandom);
		endcase
		if ($urandom_range(11) != 0) b[SYNC_BIT] = 1'b0;
		return b;
	endfunction

	task automatic queue_random_packet();
		logic [7:0] f, bw;
		f = 8'($urandom);
		f[SYNC_BIT] = 1'b1;
		if ($urandom_range(99) >= 8) f[OVF_Y_BIT:OVF_X_BIT] = 2'b00;
		if ($urandom_range(1) == 0) f[2:0] = last_btn;
		last_btn = f[2:0];
		bw = 8'($urandom);
		if ($urandom_range(9) != 0) bw[SYNC_BIT] = 1'b0;
		if ($urandom_range(3) == 0) bw[3:0] = 4'h0;
		queue_packet(f, rand_delta(), rand_delta(), bw);
	endtask

	task automatic queue_random_words(input int n);
		int stop;
		stop = words_made + n;
		while (words_made < stop) begin
			case ($urandom_range(19))
				0: queue_setpos(rand_pos(), rand_pos());
				1, 2: queue_byte(8'($urandom));
				default: queue_random_packet();
			endcase
		end
	endtask

	// Driver: hold the word until taken, then offer the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) track_word(cur_word);
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_word = pending_words.pop_front();
					kind <= cur_word.kind;
					rx_byte <= cur_word.rx;
					new_x <= cur_word.nx;
					new_y <= cur_word.ny;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input logic signed [31:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: compare each taken event with the oldest expected one
	always @(posedge clk) begin
		mouse_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_events.size() == 0) begin
				$error("event_type: expected no event, got %0d", event_type);
				mismatches++;
			end else begin
				want = due_events.pop_front();
				check_field("event_type", want.ev, event_type);
				check_field("cursor_x", want.cx, cursor_x);
				check_field("cursor_y", want.cy, cursor_y);
				check_field("delta_x", want.dx, delta_x);
				check_field("delta_y", want.dy, delta_y);
				check_field("wheel_step", want.wh, wheel_step);
				check_field("button_bits", want.btn, button_bits);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// disabled device: bytes dropped, set-position still applies
		@(negedge clk);
		queue_byte(8'h08);
		queue_byte(8'h01);
		queue_setpos(-13'sd2048, 13'sd4095);
		settle();

		// three-byte packets: sync loss, press/release, no change, overflow, resync
		apply_setup(1, 639, 479, 1, 1, 0);
		@(negedge clk);
		queue_byte(8'h00);
		queue_byte(8'hF7);
		queue_packet(8'h09, 8'h80, 8'h80, 8'h00);
		queue_packet(8'h08, 8'h77, 8'h00, 8'h00);
		queue_packet(8'h08, 8'h00, 8'h00, 8'h00);
		queue_packet(8'h4F, 8'h10, 8'h10, 8'h00);
		queue_packet(8'h8F, 8'h10, 8'h10, 8'h00);
		queue_byte(8'h08);
		queue_packet(8'h0E, 8'h01, 8'hF0, 8'h00);
		queue_setpos(13'sd4095, -13'sd1);
		queue_packet(8'h0A, 8'hFF, 8'h01, 8'h00);
		settle();

		// four-byte packets, saturated divisors, scroll and resync on the wheel byte
		apply_setup(1, 4095, 4095, 0, 15, 1);
		@(negedge clk);
		queue_packet(8'h08, 8'h00, 8'h00, 8'h07);
		queue_packet(8'h18, 8'h05, 8'hF9, 8'hF0);
		queue_byte(8'h08);
		queue_byte(8'h81);
		queue_byte(8'h07);
		queue_byte(8'h0F);
		queue_byte(8'h00);
		queue_byte(8'h00);
		queue_byte(8'h01);
		settle();

		// random phases over settings and idle patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_setup(1, 639, 479, 1, 1, 0);
				1: apply_setup(1, 4095, 4095, 8, 8, 1);
				2: apply_setup(1, 0, 0, 0, 15, 1);
				3: apply_setup(0, 639, 479, 1, 1, 0);
				default: apply_setup(1, $urandom_range(4095), $urandom_range(4095),
					$urandom_range(15), $urandom_range(15), $urandom_range(1));
			endcase
			@(negedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 56; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 56; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			queue_random_words(ph == 3 ? 40 : 230);
			// long output hold-off while the sender keeps pushing
			if (ph == 0) hold_req = ~hold_req;
			// leave a packet open across the register writes
			queue_byte(8'h08 | 8'($urandom_range(7)));
			queue_byte(8'h01);
			settle();
		end

		if (mismatches == 0 && due_events.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
